// ===== rtl/tty_line_discipline_top_macros.svh =====
// assertion macros shared by the line discipline rtl
// no dependencies
`ifndef TTY_LINE_DISCIPLINE_TOP_MACROS_SVH
`define TTY_LINE_DISCIPLINE_TOP_MACROS_SVH
// implication checked on every clock, quiet in reset
`define TLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/tld_pkg.sv =====
// types and constants of the tty line discipline
// no dependencies
package tld_pkg;
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_char;
  } in_req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } out_req_t;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] K_ECHO  = 3'd0;
  localparam logic [2:0] K_CLEAR = 3'd1;
  localparam logic [2:0] K_INTR  = 3'd2;
  localparam logic [2:0] K_SUSP  = 3'd3;
  localparam logic [2:0] K_WAKE  = 3'd4;
  localparam logic [2:0] K_BYTE  = 3'd5;
  localparam logic [2:0] K_EMPTY = 3'd6;
  localparam logic [2:0] K_EOF   = 3'd7;

  localparam logic CFG_RAW  = 1'b0;
  localparam logic CFG_ECHO = 1'b1;

  localparam logic [7:0] CH_INTR = 8'h03;
  localparam logic [7:0] CH_EOF  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SUSP = 8'h1A;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_Z    = 8'h5A;

  // classified command passed from front to back
  typedef enum logic [3:0] {
    CMD_POP, CMD_RAW, CMD_INTR, CMD_SUSP, CMD_EOF, CMD_FF,
    CMD_BS, CMD_ENTER, CMD_APPEND, CMD_NONE
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
  } cmd_t;
endpackage

// ===== rtl/tld_ram.sv =====
// generic single-port-write, one-read ram with registered read
// no dependencies
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/tld_front.sv =====
// front end: takes requests and classifies them into commands
// depends on tld_pkg
module tld_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tld_pkg::in_req_t in_req,
  input  logic             raw_mode,
  output logic             q_valid,
  input  logic             q_ready,
  output tld_pkg::cmd_t    q_cmd
);
  // two-entry queue
  tld_pkg::cmd_t q_mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  tld_pkg::cmd_t cls;
  logic          push, pop;

  always_comb begin
    cls.ch = in_req.rx_char;
    if (in_req.opcode == tld_pkg::OP_POP) cls.cmd = tld_pkg::CMD_POP;
    else if (raw_mode) cls.cmd = tld_pkg::CMD_RAW;
    else begin
      unique case (in_req.rx_char)
        tld_pkg::CH_INTR:                cls.cmd = tld_pkg::CMD_INTR;
        tld_pkg::CH_SUSP:                cls.cmd = tld_pkg::CMD_SUSP;
        tld_pkg::CH_EOF:                 cls.cmd = tld_pkg::CMD_EOF;
        tld_pkg::CH_FF:                  cls.cmd = tld_pkg::CMD_FF;
        tld_pkg::CH_DEL, tld_pkg::CH_BS: cls.cmd = tld_pkg::CMD_BS;
        tld_pkg::CH_CR, tld_pkg::CH_LF:  cls.cmd = tld_pkg::CMD_ENTER;
        default:                         cls.cmd = tld_pkg::CMD_APPEND;
      endcase
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/tld_back.sv =====
// back end: line editor, ring and result sequencer
// depends on tld_pkg, tld_ram, tty_line_discipline_top_macros.svh
`include "tty_line_discipline_top_macros.svh"
module tld_back #(
  parameter int LINE_SIZE = 64,
  parameter int RING_SIZE = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  tld_pkg::cmd_t     q_cmd,
  input  logic              echo_en,
  input  logic              clr_line,
  output logic              out_valid,
  input  logic              out_stall,
  output tld_pkg::out_req_t out_req
);
  localparam int LAW = $clog2(LINE_SIZE);
  localparam int LFW = $clog2(LINE_SIZE + 1);
  localparam int RAW = $clog2(RING_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_RD, S_WALK, S_TAIL, S_POPRD
  } state_e;

  state_e        state_r;
  tld_pkg::cmd_t cmd_r;
  logic [1:0]    step_r;
  logic [LFW-1:0] fill_r, idx_r;
  logic [RAW-1:0] wp_r, rp_r;
  logic          eof_r;
  logic          ov_r;
  tld_pkg::out_req_t oreq_r;

  logic           l_we;
  logic [LAW-1:0] l_wa, l_ra;
  logic [7:0]     l_rd;
  logic           r_we;
  logic [RAW-1:0] r_wa, r_ra;
  logic [7:0]     r_wd, r_rd;

  logic           slot;
  logic [RAW-1:0] wp_inc;
  assign slot = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_req = oreq_r;
  assign wp_inc = (wp_r == RAW'(RING_SIZE - 1)) ? '0 : wp_r + 1'b1;
  assign q_ready = (state_r == S_IDLE);

  tld_ram #(.WIDTH(8), .DEPTH(LINE_SIZE)) u_line (
    .clk, .wr_en(l_we), .wr_addr(l_wa), .wr_data(cmd_r.ch),
    .rd_addr(l_ra), .rd_data(l_rd));
  tld_ram #(.WIDTH(8), .DEPTH(RING_SIZE)) u_ring (
    .clk, .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
    .rd_addr(r_ra), .rd_data(r_rd));

  assign l_ra = idx_r[LAW-1:0];
  assign r_ra = rp_r;
  assign l_wa = fill_r[LAW-1:0];
  assign r_wa = wp_r;

  // line echo of fixed three-byte sequences
  function automatic logic [7:0] seq_byte(tld_pkg::cmd_e c, logic [1:0] s);
    logic [7:0] b;
    b = 8'h00;
    unique case (c)
      tld_pkg::CMD_INTR: b = (s == 2'd0) ? tld_pkg::CH_CARET :
                             (s == 2'd1) ? tld_pkg::CH_C : tld_pkg::CH_LF;
      tld_pkg::CMD_SUSP: b = (s == 2'd0) ? tld_pkg::CH_CARET :
                             (s == 2'd1) ? tld_pkg::CH_Z : tld_pkg::CH_LF;
      tld_pkg::CMD_BS:   b = (s == 2'd1) ? tld_pkg::CH_SP : tld_pkg::CH_BS;
      default:           b = 8'h00;
    endcase
    return b;
  endfunction

  // emits one result, returns nothing; writes go through nxt signals
  state_e        state_nxt;
  logic [1:0]    step_nxt;
  logic [LFW-1:0] fill_nxt, idx_nxt;
  logic [RAW-1:0] wp_nxt, rp_nxt;
  logic          eof_nxt, ov_nxt;
  tld_pkg::out_req_t oreq_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    eof_nxt   = eof_r;
    ov_nxt    = ov_r && out_stall;
    oreq_nxt  = oreq_r;
    l_we      = 1'b0;
    r_we      = 1'b0;
    r_wd      = cmd_r.ch;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = 2'd0;
        idx_nxt  = '0;
        if (q_valid) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // dispatch state of a command; command is in cmd_r
        unique case (cmd_r.cmd)
          tld_pkg::CMD_POP: state_nxt = S_POPRD;
          tld_pkg::CMD_RAW: begin
            if (slot) begin
              if (wp_inc != rp_r) begin
                r_we = 1'b1;
                wp_nxt = wp_inc;
              end
              ov_nxt = 1'b1;
              oreq_nxt = '{tld_pkg::K_WAKE, 8'h00, 1'b1};
              state_nxt = S_IDLE;
            end
          end
          tld_pkg::CMD_INTR, tld_pkg::CMD_SUSP, tld_pkg::CMD_BS: begin
            if (cmd_r.cmd == tld_pkg::CMD_BS && fill_r == '0 && step_r == 2'd0) begin
              state_nxt = S_IDLE;
            end else if (step_r == 2'd3 || !echo_en) begin
              if (cmd_r.cmd == tld_pkg::CMD_BS) begin
                fill_nxt = fill_r - 1'b1;
                state_nxt = S_IDLE;
              end else if (slot) begin
                ov_nxt = 1'b1;
                oreq_nxt = '{(cmd_r.cmd == tld_pkg::CMD_INTR) ? tld_pkg::K_INTR
                             : tld_pkg::K_SUSP, 8'h00, 1'b1};
                if (cmd_r.cmd == tld_pkg::CMD_INTR) fill_nxt = '0;
                state_nxt = S_IDLE;
              end
            end else if (slot) begin
              ov_nxt = 1'b1;
              oreq_nxt = '{tld_pkg::K_ECHO, seq_byte(cmd_r.cmd, step_r),
                           (cmd_r.cmd == tld_pkg::CMD_BS) && step_r == 2'd2};
              step_nxt = step_r + 1'b1;
            end
          end
          tld_pkg::CMD_EOF: begin
            if (fill_r == '0) begin
              if (slot) begin
                eof_nxt = 1'b1;
                ov_nxt = 1'b1;
                oreq_nxt = '{tld_pkg::K_WAKE, 8'h00, 1'b1};
                state_nxt = S_IDLE;
              end
            end else state_nxt = S_RD;
          end
          tld_pkg::CMD_ENTER: begin
            if (!echo_en || step_r != 2'd0) state_nxt = S_RD;
            else if (slot) begin
              ov_nxt = 1'b1;
              oreq_nxt = '{tld_pkg::K_ECHO, tld_pkg::CH_LF, 1'b0};
              step_nxt = 2'd1;
            end
          end
          tld_pkg::CMD_FF: begin
            if (slot) begin
              ov_nxt = 1'b1;
              oreq_nxt = '{tld_pkg::K_CLEAR, 8'h00, !echo_en || fill_r == '0};
              state_nxt = (!echo_en || fill_r == '0) ? S_IDLE : S_RD;
            end
          end
          tld_pkg::CMD_APPEND: begin
            if (fill_r >= LFW'(LINE_SIZE - 1)) state_nxt = S_IDLE;
            else if (!echo_en) begin
              l_we = 1'b1;
              fill_nxt = fill_r + 1'b1;
              state_nxt = S_IDLE;
            end else if (slot) begin
              l_we = 1'b1;
              fill_nxt = fill_r + 1'b1;
              ov_nxt = 1'b1;
              oreq_nxt = '{tld_pkg::K_ECHO, cmd_r.ch, 1'b1};
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        // line read issued for idx_r, data valid next cycle
        state_nxt = (idx_r < fill_r) ? S_WALK : S_TAIL;
      end
      S_WALK: begin
        if (cmd_r.cmd == tld_pkg::CMD_FF) begin
          if (slot) begin
            ov_nxt = 1'b1;
            oreq_nxt = '{tld_pkg::K_ECHO, l_rd, idx_r + 1'b1 == fill_r};
            idx_nxt = idx_r + 1'b1;
            state_nxt = (idx_r + 1'b1 == fill_r) ? S_IDLE : S_RD;
          end
        end else begin
          r_wd = l_rd;
          if (wp_inc != rp_r) begin
            r_we = 1'b1;
            wp_nxt = wp_inc;
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_TAIL: begin
        // flush tail: optional newline, then wake
        if (cmd_r.cmd == tld_pkg::CMD_ENTER && step_r != 2'd2) begin
          r_wd = tld_pkg::CH_LF;
          if (wp_inc != rp_r) begin
            r_we = 1'b1;
            wp_nxt = wp_inc;
          end
          step_nxt = 2'd2;
        end else if (slot) begin
          fill_nxt = '0;
          ov_nxt = 1'b1;
          oreq_nxt = '{tld_pkg::K_WAKE, 8'h00, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_POPRD: begin
        if (slot) begin
          ov_nxt = 1'b1;
          if (rp_r != wp_r) begin
            oreq_nxt = '{tld_pkg::K_BYTE, r_rd, 1'b1};
            rp_nxt = (rp_r == RAW'(RING_SIZE - 1)) ? '0 : rp_r + 1'b1;
          end else if (eof_r) begin
            eof_nxt = 1'b0;
            oreq_nxt = '{tld_pkg::K_EOF, 8'h00, 1'b1};
          end else begin
            oreq_nxt = '{tld_pkg::K_EMPTY, 8'h00, 1'b1};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (clr_line) fill_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) cmd_r <= q_cmd;
    oreq_r <= oreq_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      eof_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      eof_r   <= eof_nxt;
      ov_r    <= ov_nxt;
    end
  end

  `TLD_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_r <= LFW'(LINE_SIZE - 1))
  `TLD_ASSERT_IMP(a_ring_ptr, clk, rst_n, 1'b1,
    wp_r <= RAW'(RING_SIZE - 1) && rp_r <= RAW'(RING_SIZE - 1))
  `TLD_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && out_stall, ov_r && $stable(oreq_r))
  `TLD_ASSERT_IMP(a_idle_no_take, clk, rst_n, state_r != S_IDLE, !q_ready)
endmodule

// ===== rtl/tty_line_discipline_top.sv =====
// tty line discipline: cooked line editor and read ring
// depends on tld_pkg, tld_front, tld_back, tld_ram
//
// usage: in channel carries requests {opcode, rx_char}: opcode 0 is a
// received character, 1 a reader pop. out channel carries results
// {kind, data_byte, last}; last marks the final result of a request.
// cfg channel writes raw_mode (index 0) and echo_enable (index 1); the user
// must write it only while idle, which the block does not enforce. a line
// flush or a clear screen re-echo walks the line store byte by byte. the
// sequencer runs one request at a time; a two-entry queue between the
// classifier and the sequencer lets input arrive while the back end works.
// results wait in an output register while out_stall is high, and the
// sequencer holds until it is taken. synchronous reset empties the ring,
// the line and the end of file flag; raw_mode resets to 0, echo to 1.
// stores are undefined after reset and need no clearing pass.
module tty_line_discipline_top #(
  parameter int LINE_SIZE = 64,
  parameter int RING_SIZE = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tld_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output tld_pkg::out_req_t out_req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic              cfg_data
);
  logic          raw_r, echo_r;
  logic          q_valid, q_ready;
  tld_pkg::cmd_t q_cmd;
  logic          clr_line;

  assign cfg_ready = 1'b1;
  assign clr_line = cfg_valid && cfg_index == tld_pkg::CFG_RAW && cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b0;
      echo_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == tld_pkg::CFG_RAW) raw_r <= cfg_data;
      else echo_r <= cfg_data;
    end
  end

  tld_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req, .raw_mode(raw_r),
    .q_valid, .q_ready, .q_cmd);

  tld_back #(.LINE_SIZE(LINE_SIZE), .RING_SIZE(RING_SIZE)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .echo_en(echo_r),
    .clr_line, .out_valid, .out_stall, .out_req);
endmodule
